// File: design/rdcc_pkg.sv
// Shared types, codes and helper functions for the refcount delta coalescing cache.
// No dependencies; used by rdcc_front, rdcc_back and the top level.
package rdcc_pkg;

	localparam int KEY_W   = 48;
	localparam int DELTA_W = 32;
	localparam int SUM_W   = 64;
	localparam int HITS_W  = 32;
	localparam int EXP_W   = 6;
	localparam int KIND_W  = 3;
	localparam int SET_W   = 4;
	localparam int CNT_W   = 7;
	localparam int CAP     = 64;

	localparam int NUM_SETS_DEF  = 16;
	localparam int NUM_WAYS_DEF  = 4;
	localparam int SET_SHIFT_DEF = 3;

	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BYPASS = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FFLUSH = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [KEY_W-1:0]          key;
		logic signed [DELTA_W-1:0] delta;
		logic [SET_W-1:0]          set;
	} item_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SUM_W-1:0]  sum;
		logic [HITS_W-1:0] hits;
		logic [EXP_W-1:0]  exp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [SUM_W-1:0] magnitude(input logic [SUM_W-1:0] s);
		return s[SUM_W-1] ? (~s + 64'd1) : s;
	endfunction

	function automatic logic [EXP_W-1:0] exp_inc(input logic [EXP_W-1:0] e);
		return (e == {EXP_W{1'b1}}) ? e : e + 6'd1;
	endfunction

	// e is the already incremented exponent
	function automatic logic flush_emit(input logic [EXP_W-1:0] e,
		input logic [HITS_W-1:0] hits, input logic force_all);
		return force_all || e[5] || ((32'd1 << e[4:0]) >= hits);
	endfunction

endpackage

// File: design/refcount_delta_coalescing_cache_unit.sv
// Top level of the refcount delta coalescing cache.
// Depends on rdcc_pkg, rdcc_front, rdcc_back (which uses rdcc_ram).
//
// Usage: items (kind, object_key, delta_in) transfer on in_valid/in_ready; results
// (emitted, out_key, out_delta, is_increment, last_of_run, dirty) transfer on
// out_valid/out_ready. Every item yields one or more results; the last carries
// last_of_run.
// The front end takes an item, finds its set (the low key bits above SET_SHIFT for a
// power-of-two set count, else for writes a remainder built one key digit at a
// time) and places it in a two-entry queue, so it keeps accepting while the back
// end works. Bypass, reset and ignored items go straight to a result; a cached
// write reads the set and updates a hit or free way, or evicts a victim (the ways
// of the set are read in parallel from one RAM per way, the victim search takes
// one way per cycle). A flush first counts emitting entries set by set, then walks
// the sets one entry per cycle, holding on an emitted group while the result
// register is held.
// Results sit in one output register; while it holds a result and out_ready is
// low the back end stalls, and the queue then fills and in_ready drops.
// Reset (arst_n) clears all entries at once; no clearing pass is needed.
module refcount_delta_coalescing_cache_unit #(
	parameter int NUM_SETS  = rdcc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS  = rdcc_pkg::NUM_WAYS_DEF,
	parameter int SET_SHIFT = rdcc_pkg::SET_SHIFT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rdcc_pkg::KIND_W-1:0]         kind,
	input  logic [rdcc_pkg::KEY_W-1:0]          object_key,
	input  logic signed [rdcc_pkg::DELTA_W-1:0] delta_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                emitted,
	output logic [rdcc_pkg::KEY_W-1:0]          out_key,
	output logic signed [rdcc_pkg::SUM_W-1:0]   out_delta,
	output logic                                is_increment,
	output logic                                last_of_run,
	output logic                                dirty
);

	localparam int WAYS_USED = (NUM_SETS * NUM_WAYS > rdcc_pkg::CAP)
		? (rdcc_pkg::CAP / NUM_SETS) : NUM_WAYS;

	logic            q_valid;
	logic            q_ready;
	rdcc_pkg::item_t q_item;

	rdcc_front #(
		.NUM_SETS  (NUM_SETS),
		.SET_SHIFT (SET_SHIFT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.object_key (object_key),
		.delta_in   (delta_in),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_ready    (q_ready)
	);

	rdcc_back #(
		.NUM_SETS  (NUM_SETS),
		.WAYS_USED (WAYS_USED)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_ready      (q_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.emitted      (emitted),
		.out_key      (out_key),
		.out_delta    (out_delta),
		.is_increment (is_increment),
		.last_of_run  (last_of_run),
		.dirty        (dirty)
	);

endmodule

// File: design/rdcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// File: design/rdcc_front.sv
// Front end: accepts items, derives the set index, queues items for the back end.
// Depends on rdcc_pkg.
module rdcc_front #(
	parameter int NUM_SETS  = rdcc_pkg::NUM_SETS_DEF,
	parameter int SET_SHIFT = rdcc_pkg::SET_SHIFT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rdcc_pkg::KIND_W-1:0]        kind,
	input  logic [rdcc_pkg::KEY_W-1:0]         object_key,
	input  logic signed [rdcc_pkg::DELTA_W-1:0] delta_in,
	output logic                               q_valid,
	output rdcc_pkg::item_t                    q_item,
	input  logic                               q_ready
);

	localparam bit POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
	localparam int NIBS = rdcc_pkg::KEY_W / 4;

	rdcc_pkg::item_t                stg_item_q;
	logic                           stg_valid_q;
	logic                           stg_done_q;
	logic [rdcc_pkg::KEY_W-1:0]     stg_v_q;
	logic [3:0]                     nib_q;
	logic [rdcc_pkg::KEY_W-1:0]     v_in;
	logic [rdcc_pkg::SET_W-1:0]     set_direct;
	logic [7:0]                     red;

	rdcc_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	logic            push;
	logic            pop;

	assign v_in       = object_key >> SET_SHIFT;
	assign set_direct = rdcc_pkg::SET_W'(v_in[rdcc_pkg::SET_W-1:0])
		& rdcc_pkg::SET_W'(NUM_SETS - 1);
	assign in_ready   = !stg_valid_q;

	// one remainder digit per cycle: (r * 16 + nibble) mod NUM_SETS
	always_comb begin
		red = {stg_item_q.set, stg_v_q[rdcc_pkg::KEY_W-1 -: 4]};
		for (int j = 3; j >= 0; j--) begin
			if (red >= (8'(NUM_SETS) << j))
				red = red - (8'(NUM_SETS) << j);
		end
	end

	assign push    = stg_valid_q && stg_done_q && (fill_q != 2'd2);
	assign pop     = q_valid && q_ready;
	assign q_valid = fill_q != 2'd0;
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
			stg_done_q  <= 1'b0;
			nib_q       <= '0;
		end else begin
			if (in_valid && in_ready) begin
				stg_valid_q <= 1'b1;
				stg_done_q  <= POW2 || (kind != rdcc_pkg::KIND_WRITE);
				nib_q       <= '0;
			end else if (push) begin
				stg_valid_q <= 1'b0;
			end else if (stg_valid_q && !stg_done_q) begin
				nib_q <= nib_q + 4'd1;
				if (nib_q == 4'(NIBS - 1))
					stg_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			stg_item_q.kind  <= kind;
			stg_item_q.key   <= object_key;
			stg_item_q.delta <= delta_in;
			stg_item_q.set   <= POW2 ? set_direct : '0;
			stg_v_q          <= v_in;
		end else if (stg_valid_q && !stg_done_q) begin
			stg_item_q.set <= red[rdcc_pkg::SET_W-1:0];
			stg_v_q        <= stg_v_q << 4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= stg_item_q;
	end

endmodule

// File: design/rdcc_back.sv
// Back end: executes queued items against the way RAMs and drives the result register.
// Depends on rdcc_pkg and rdcc_ram.
module rdcc_back #(
	parameter int NUM_SETS  = rdcc_pkg::NUM_SETS_DEF,
	parameter int WAYS_USED = rdcc_pkg::NUM_WAYS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  rdcc_pkg::item_t                   q_item,
	output logic                              q_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              emitted,
	output logic [rdcc_pkg::KEY_W-1:0]        out_key,
	output logic signed [rdcc_pkg::SUM_W-1:0] out_delta,
	output logic                              is_increment,
	output logic                              last_of_run,
	output logic                              dirty
);

	localparam int SW = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
	localparam int WW = WAYS_USED > 1 ? $clog2(WAYS_USED) : 1;
	localparam int SUM_W = rdcc_pkg::SUM_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_W_RD  = 4'd1;
	localparam logic [3:0] ST_W_CHK = 4'd2;
	localparam logic [3:0] ST_W_ACT = 4'd3;
	localparam logic [3:0] ST_W_SCN = 4'd4;
	localparam logic [3:0] ST_W_EVT = 4'd5;
	localparam logic [3:0] ST_ONE   = 4'd6;
	localparam logic [3:0] ST_P_RD  = 4'd7;
	localparam logic [3:0] ST_P_CHK = 4'd8;
	localparam logic [3:0] ST_F_RD  = 4'd9;
	localparam logic [3:0] ST_F_WAY = 4'd10;
	localparam logic [3:0] ST_F_END = 4'd11;

	logic [3:0]                         state_q;
	rdcc_pkg::item_t                    cur_q;
	logic [SW-1:0]                      set_q;
	logic [WW-1:0]                      w_q;
	logic [WW-1:0]                      best_q;
	logic [SUM_W-1:0]                   bestmag_q;
	logic                               hit_q;
	logic                               empty_q;
	logic [WW-1:0]                      hidx_q;
	logic [WW-1:0]                      eidx_q;
	logic [rdcc_pkg::CNT_W-1:0]         ecnt_q;
	logic [rdcc_pkg::CNT_W-1:0]         dcnt_q;
	logic                               surv_q;
	logic [NUM_SETS-1:0][WAYS_USED-1:0] valid_q;
	logic [rdcc_pkg::CNT_W-1:0]         cnt_q;

	logic                               res_em_q;
	logic [rdcc_pkg::KEY_W-1:0]         res_key_q;
	logic [SUM_W-1:0]                   res_sum_q;
	logic                               res_dirty_q;

	logic                               out_valid_q;
	logic                               out_em_q;
	logic [rdcc_pkg::KEY_W-1:0]         out_key_q;
	logic [SUM_W-1:0]                   out_sum_q;
	logic                               out_last_q;
	logic                               out_dirty_q;

	logic [rdcc_pkg::ENTRY_W-1:0]       rdata [WAYS_USED];
	rdcc_pkg::entry_t                   ent [WAYS_USED];
	logic [WAYS_USED-1:0]               vrow;
	logic                               rd_en;
	logic                               wr_en;
	logic [WW-1:0]                      wr_way;
	rdcc_pkg::entry_t                   wr_data;

	logic [SUM_W-1:0]                   dext;
	rdcc_pkg::entry_t                   hent;
	rdcc_pkg::entry_t                   sel;
	rdcc_pkg::entry_t                   new_ent;
	logic [SUM_W-1:0]                   nsum;
	logic [rdcc_pkg::HITS_W-1:0]        hits_inc;
	logic [rdcc_pkg::EXP_W-1:0]         e_n;
	logic                               force_all;
	logic                               sel_valid;
	logic                               f_emit;
	logic                               f_adv;
	logic                               push_ok;
	logic                               push;
	logic                               p_em;
	logic [rdcc_pkg::KEY_W-1:0]         p_key;
	logic [SUM_W-1:0]                   p_sum;
	logic                               p_last;
	logic                               p_dirty;

	logic                               hit_c;
	logic                               empty_c;
	logic [WW-1:0]                      hidx_c;
	logic [WW-1:0]                      eidx_c;
	logic [3:0]                         pcnt_c;
	logic                               psurv_c;
	logic [SUM_W-1:0]                   scan_mag;
	logic                               last_way;
	logic                               last_set;

	for (genvar w = 0; w < WAYS_USED; w++) begin : g_way
		rdcc_ram #(
			.WIDTH(rdcc_pkg::ENTRY_W),
			.DEPTH(NUM_SETS)
		) u_ram (
			.clk   (clk),
			.we    (wr_en && (wr_way == WW'(w))),
			.waddr (set_q),
			.wdata (wr_data),
			.re    (rd_en),
			.raddr (set_q),
			.rdata (rdata[w])
		);
		assign ent[w] = rdcc_pkg::entry_t'(rdata[w]);
	end

	assign vrow      = valid_q[set_q];
	assign rd_en     = (state_q == ST_W_RD) || (state_q == ST_P_RD) || (state_q == ST_F_RD);
	assign q_ready   = state_q == ST_IDLE;
	assign push_ok   = !out_valid_q || out_ready;
	assign force_all = cur_q.kind == rdcc_pkg::KIND_FFLUSH;
	assign dext      = SUM_W'(cur_q.delta);
	assign hent      = ent[hidx_q];
	assign sel       = ent[w_q];
	assign nsum      = hent.sum + dext;
	assign hits_inc  = (&hent.hits) ? hent.hits : hent.hits + 32'd1;
	assign e_n       = rdcc_pkg::exp_inc(sel.exp);
	assign sel_valid = vrow[w_q];
	assign f_emit    = rdcc_pkg::flush_emit(e_n, sel.hits, force_all);
	assign f_adv     = !sel_valid || !f_emit || push_ok;
	assign scan_mag  = rdcc_pkg::magnitude(sel.sum);
	assign last_way  = w_q == WW'(WAYS_USED - 1);
	assign last_set  = set_q == SW'(NUM_SETS - 1);

	always_comb begin
		new_ent.key  = cur_q.key;
		new_ent.sum  = dext;
		new_ent.hits = '0;
		new_ent.exp  = '0;
	end

	always_comb begin
		hit_c   = 1'b0;
		empty_c = 1'b0;
		hidx_c  = '0;
		eidx_c  = '0;
		pcnt_c  = '0;
		psurv_c = 1'b0;
		for (int w = WAYS_USED - 1; w >= 0; w--) begin
			if (vrow[w] && (ent[w].key == cur_q.key)) begin
				hit_c  = 1'b1;
				hidx_c = WW'(w);
			end
			if (!vrow[w]) begin
				empty_c = 1'b1;
				eidx_c  = WW'(w);
			end
		end
		for (int w = 0; w < WAYS_USED; w++) begin
			if (vrow[w]) begin
				if (rdcc_pkg::flush_emit(rdcc_pkg::exp_inc(ent[w].exp), ent[w].hits, force_all))
					pcnt_c = pcnt_c + 4'd1;
				else
					psurv_c = 1'b1;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_way  = w_q;
		wr_data = new_ent;
		unique case (state_q)
			ST_W_ACT: begin
				if (hit_q) begin
					wr_en        = 1'b1;
					wr_way       = hidx_q;
					wr_data.key  = hent.key;
					wr_data.sum  = nsum;
					wr_data.hits = hits_inc;
					wr_data.exp  = hent.exp;
				end else if (empty_q) begin
					wr_en  = 1'b1;
					wr_way = eidx_q;
				end
			end
			ST_W_EVT: begin
				wr_en  = 1'b1;
				wr_way = best_q;
			end
			ST_F_WAY: begin
				if (sel_valid && f_adv) begin
					wr_en        = 1'b1;
					wr_data.key  = sel.key;
					wr_data.sum  = sel.sum;
					wr_data.hits = sel.hits;
					wr_data.exp  = e_n;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		push    = 1'b0;
		p_em    = res_em_q;
		p_key   = res_key_q;
		p_sum   = res_sum_q;
		p_last  = 1'b1;
		p_dirty = res_dirty_q;
		unique case (state_q)
			ST_ONE:
				push = push_ok;
			ST_F_WAY: begin
				push    = sel_valid && f_emit && push_ok;
				p_em    = 1'b1;
				p_key   = sel.key;
				p_sum   = sel.sum;
				p_last  = (dcnt_q + 7'd1) == ecnt_q;
				p_dirty = surv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			cnt_q   <= '0;
			set_q   <= '0;
			w_q     <= '0;
			ecnt_q  <= '0;
			dcnt_q  <= '0;
			surv_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_item.kind)
							rdcc_pkg::KIND_WRITE: begin
								set_q <= q_item.set[SW-1:0];
								state_q <= (q_item.key != '0) ? ST_W_RD : ST_ONE;
							end
							rdcc_pkg::KIND_FLUSH, rdcc_pkg::KIND_FFLUSH: begin
								set_q   <= '0;
								ecnt_q  <= '0;
								dcnt_q  <= '0;
								surv_q  <= 1'b0;
								state_q <= ST_P_RD;
							end
							rdcc_pkg::KIND_RESET: begin
								valid_q <= '0;
								cnt_q   <= '0;
								state_q <= ST_ONE;
							end
							default:
								state_q <= ST_ONE;
						endcase
					end
				end
				ST_W_RD:
					state_q <= ST_W_CHK;
				ST_W_CHK: begin
					w_q     <= WW'(1);
					state_q <= ST_W_ACT;
				end
				ST_W_ACT: begin
					if (hit_q) begin
						if (nsum == '0) begin
							valid_q[set_q][hidx_q] <= 1'b0;
							cnt_q <= cnt_q - 7'd1;
						end
						state_q <= ST_ONE;
					end else if (empty_q) begin
						valid_q[set_q][eidx_q] <= 1'b1;
						cnt_q   <= cnt_q + 7'd1;
						state_q <= ST_ONE;
					end else begin
						state_q <= (WAYS_USED > 1) ? ST_W_SCN : ST_W_EVT;
					end
				end
				ST_W_SCN: begin
					if (last_way)
						state_q <= ST_W_EVT;
					else
						w_q <= w_q + WW'(1);
				end
				ST_W_EVT:
					state_q <= ST_ONE;
				ST_ONE: begin
					if (push_ok)
						state_q <= ST_IDLE;
				end
				ST_P_RD:
					state_q <= ST_P_CHK;
				ST_P_CHK: begin
					ecnt_q <= ecnt_q + 7'(pcnt_c);
					surv_q <= surv_q || psurv_c;
					if (last_set) begin
						set_q   <= '0;
						state_q <= ST_F_RD;
					end else begin
						set_q   <= set_q + SW'(1);
						state_q <= ST_P_RD;
					end
				end
				ST_F_RD: begin
					w_q     <= '0;
					state_q <= ST_F_WAY;
				end
				ST_F_WAY: begin
					if (f_adv) begin
						if (sel_valid && f_emit) begin
							valid_q[set_q][w_q] <= 1'b0;
							cnt_q  <= cnt_q - 7'd1;
							dcnt_q <= dcnt_q + 7'd1;
						end
						if (!last_way) begin
							w_q <= w_q + WW'(1);
						end else if (last_set) begin
							state_q <= ST_F_END;
						end else begin
							set_q   <= set_q + SW'(1);
							state_q <= ST_F_RD;
						end
					end
				end
				ST_F_END:
					state_q <= (ecnt_q == '0) ? ST_ONE : ST_IDLE;
				default:
					state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q       <= q_item;
				res_em_q    <= 1'b0;
				res_key_q   <= '0;
				res_sum_q   <= '0;
				res_dirty_q <= cnt_q != '0;
				if (q_item.kind == rdcc_pkg::KIND_BYPASS && q_item.key != '0) begin
					res_em_q  <= 1'b1;
					res_key_q <= q_item.key;
					res_sum_q <= SUM_W'(q_item.delta);
				end
				if (q_item.kind == rdcc_pkg::KIND_RESET)
					res_dirty_q <= 1'b0;
			end
			ST_W_CHK: begin
				hit_q     <= hit_c;
				empty_q   <= empty_c;
				hidx_q    <= hidx_c;
				eidx_q    <= eidx_c;
				best_q    <= '0;
				bestmag_q <= rdcc_pkg::magnitude(ent[0].sum);
			end
			ST_W_ACT: begin
				if (hit_q)
					res_dirty_q <= (cnt_q - 7'(nsum == '0)) != '0;
				else
					res_dirty_q <= 1'b1;
			end
			ST_W_SCN: begin
				if (scan_mag < bestmag_q) begin
					bestmag_q <= scan_mag;
					best_q    <= w_q;
				end
			end
			ST_W_EVT: begin
				res_em_q    <= 1'b1;
				res_key_q   <= ent[best_q].key;
				res_sum_q   <= ent[best_q].sum;
				res_dirty_q <= 1'b1;
			end
			ST_F_END:
				res_dirty_q <= surv_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_em_q    <= p_em;
			out_key_q   <= p_key;
			out_sum_q   <= p_sum;
			out_last_q  <= p_last;
			out_dirty_q <= p_dirty;
		end
	end

	assign out_valid    = out_valid_q;
	assign emitted      = out_em_q;
	assign out_key      = out_key_q;
	assign out_delta    = out_sum_q;
	assign is_increment = out_em_q && !out_sum_q[SUM_W-1];
	assign last_of_run  = out_last_q;
	assign dirty        = out_dirty_q;

	a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) == $countones(valid_q))
		else $error("occupancy count out of step with valid bits");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !emitted |-> last_of_run)
		else $error("empty result not marked last");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_F_WAY |-> dcnt_q < ecnt_q || !(sel_valid && f_emit))
		else $error("flush emitted more groups than counted");

	a_evict_full_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_W_EVT |-> &vrow)
		else $error("eviction from a set with a free way");

endmodule
